/* src/bale_pkg.sv */
`default_nettype none
package bale_pkg;

   // list geometry
   localparam int CAPACITY = 16;
   localparam int DATA_W   = 32;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   // fixed beat field widths
   localparam int KIND_W   = 3;
   localparam int POS_W    = 5;
   localparam int STATUS_W = 2;
   localparam int FOUND_W  = 4;
   localparam int COUNT_W  = 5;

   // common width for index, position and count compares
   localparam int CMP_W0 = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam int CMP_W  = (CMP_W0 > COUNT_W) ? CMP_W0 : COUNT_W;

   // request kinds
   typedef enum logic [KIND_W-1:0] {
      KIND_INSERT_AT     = 3'd0,
      KIND_DELETE_AT     = 3'd1,
      KIND_LOCATE        = 3'd2,
      KIND_INSERT_SORTED = 3'd3,
      KIND_READ_AT       = 3'd4
   } kind_type;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 2'd0,
      ST_BAD_POS = 2'd1,
      ST_FULL    = 2'd2,
      ST_MISSING = 2'd3
   } status_type;

   // what a cell loads at the next edge
   typedef enum logic [1:0] {
      CELL_HOLD  = 2'd0,
      CELL_LEFT  = 2'd1,
      CELL_RIGHT = 2'd2,
      CELL_LOAD  = 2'd3
   } cell_op_type;

   // compare results of one cell against the request key
   typedef struct packed {
      logic match;
      logic greater;
   } cell_flags_type;

endpackage
`default_nettype wire

/* src/bale_cell.sv */
`default_nettype none
module bale_cell (
   input  wire                                       clock,
   input  wire bale_pkg::cell_op_type                op,
   input  wire logic signed [bale_pkg::DATA_W-1:0]   left_data,
   input  wire logic signed [bale_pkg::DATA_W-1:0]   right_data,
   input  wire logic signed [bale_pkg::DATA_W-1:0]   key,
   output logic signed [bale_pkg::DATA_W-1:0]        data,
   output bale_pkg::cell_flags_type                  flags
);

   logic signed [bale_pkg::DATA_W-1:0] data_ff;
   logic signed [bale_pkg::DATA_W-1:0] data_in;

   // entry select: keep, shift from a neighbor or take the key
   always_comb begin
      case (op)
         bale_pkg::CELL_HOLD:  data_in = data_ff;
         bale_pkg::CELL_LEFT:  data_in = left_data;
         bale_pkg::CELL_RIGHT: data_in = right_data;
         bale_pkg::CELL_LOAD:  data_in = key;
         default:              data_in = data_ff;
      endcase
   end

   // entry storage
   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   // local compares against the key
   always_comb begin
      flags.match   = (data_ff == key);
      flags.greater = (data_ff > key);
   end

   assign data = data_ff;

endmodule
`default_nettype wire

/* src/bounded_array_list_engine.sv */
`default_nettype none
// Packed list of signed 32-bit entries with a fill count, held in a row of
// cells, one entry per cell. Each cell shifts from either neighbor or loads
// the request value, and compares its entry with the value in parallel.
// Request channel (req_valid / req_stall): kind, value, position. Result
// channel (rsp_valid / rsp_stall): status, found_index, read_value and
// entry_count after the request. One result beat per request beat.
// The result appears in the cycle after the request is taken, from an
// output register. Throughput: one request per cycle unless the receiver
// stalls; the whole row of cells updates in the cycle the request is taken.
// When the receiver stalls, the result holds in the output register and
// req_stall rises until it is taken; no request is taken meanwhile.
// Reset (synchronous, active high) empties the list and drops rsp_valid;
// entry contents are not cleared, the count alone marks what is valid.
// Failed requests (bad position, full list) leave the list unchanged.
module bounded_array_list_engine (
   input  wire                                      clock,
   input  wire                                      reset,
   input  wire                                      req_valid,
   output logic                                     req_stall,
   input  wire logic [bale_pkg::KIND_W-1:0]         req_kind,
   input  wire logic signed [bale_pkg::DATA_W-1:0]  req_value,
   input  wire logic [bale_pkg::POS_W-1:0]          req_position,
   output logic                                     rsp_valid,
   input  wire                                      rsp_stall,
   output logic [bale_pkg::STATUS_W-1:0]            rsp_status,
   output logic [bale_pkg::FOUND_W-1:0]             rsp_found_index,
   output logic signed [bale_pkg::DATA_W-1:0]       rsp_read_value,
   output logic [bale_pkg::COUNT_W-1:0]             rsp_entry_count
);

   localparam int CAP   = bale_pkg::CAPACITY;
   localparam int CMP_W = bale_pkg::CMP_W;

   logic                                accept;
   logic [bale_pkg::CNT_W-1:0]          count_ff;
   logic [bale_pkg::CNT_W-1:0]          count_in;
   logic [CMP_W-1:0]                    cnt_e;
   logic [CMP_W-1:0]                    pos_e;
   logic [CMP_W-1:0]                    cap_e;
   logic signed [bale_pkg::DATA_W-1:0]  cell_data [CAP];
   bale_pkg::cell_flags_type            cell_flags [CAP];
   bale_pkg::cell_op_type               cell_op [CAP];
   logic [CAP-1:0]                      match_v;
   logic [CAP-1:0]                      greater_m;
   logic [CAP:0]                        suffix;
   logic                                ins_ok;
   logic                                del_ok;
   logic                                srt_ok;
   logic                                rd_ok;
   logic                                any_match;
   logic [CMP_W-1:0]                    found_e;
   logic [CMP_W-1:0]                    count_e_out;
   bale_pkg::status_type                status_c;
   logic signed [bale_pkg::DATA_W-1:0]  read_c;

   logic                                rsp_valid_ff;
   logic                                rsp_valid_in;
   logic [bale_pkg::STATUS_W-1:0]       status_ff;
   logic [bale_pkg::FOUND_W-1:0]        found_ff;
   logic signed [bale_pkg::DATA_W-1:0]  read_ff;
   logic [bale_pkg::COUNT_W-1:0]        entry_ff;

   // handshake: take a request unless a result is stuck in the output register
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   assign cnt_e = CMP_W'(count_ff);
   assign pos_e = CMP_W'(req_position);
   assign cap_e = CMP_W'(CAP);

   // per-cell compare flags, masked to live entries
   always_comb begin
      for (int i = 0; i < CAP; i++) begin
         match_v[i]   = cell_flags[i].match & (CMP_W'(i) < cnt_e);
         greater_m[i] = cell_flags[i].greater | (CMP_W'(i) >= cnt_e);
      end
   end

   // suffix of entries greater than the key, up to the end of the list
   always_comb begin
      for (int i = 0; i <= CAP; i++) begin
         suffix[i] = &({1'b1, greater_m} | ~({(CAP + 1){1'b1}} << i));
      end
   end

   // request qualification
   always_comb begin
      ins_ok = 1'b0;
      del_ok = 1'b0;
      srt_ok = 1'b0;
      rd_ok  = 1'b0;
      case (req_kind)
         bale_pkg::KIND_INSERT_AT:     ins_ok = (pos_e <= cnt_e) && (cnt_e < cap_e);
         bale_pkg::KIND_DELETE_AT:     del_ok = (pos_e < cnt_e);
         bale_pkg::KIND_INSERT_SORTED: srt_ok = (cnt_e < cap_e);
         bale_pkg::KIND_READ_AT:       rd_ok  = (pos_e < cnt_e);
         default: ;
      endcase
   end

   // per-cell operation select
   always_comb begin
      for (int i = 0; i < CAP; i++) begin
         cell_op[i] = bale_pkg::CELL_HOLD;
         if (accept) begin
            if (ins_ok) begin
               if ((CMP_W'(i) > pos_e) && (CMP_W'(i) <= cnt_e)) begin
                  cell_op[i] = bale_pkg::CELL_LEFT;
               end else if (CMP_W'(i) == pos_e) begin
                  cell_op[i] = bale_pkg::CELL_LOAD;
               end
            end else if (del_ok) begin
               if ((CMP_W'(i) >= pos_e) && ((CMP_W'(i) + CMP_W'(1)) < cnt_e)) begin
                  cell_op[i] = bale_pkg::CELL_RIGHT;
               end
            end else if (srt_ok && (CMP_W'(i) <= cnt_e)) begin
               if ((i != 0) && suffix[(i == 0) ? 0 : i - 1]) begin
                  cell_op[i] = bale_pkg::CELL_LEFT;
               end else if (suffix[i]) begin
                  cell_op[i] = bale_pkg::CELL_LOAD;
               end
            end
         end
      end
   end

   // row of cells
   for (genvar g = 0; g < CAP; g++) begin : g_cell
      logic signed [bale_pkg::DATA_W-1:0] left_d;
      logic signed [bale_pkg::DATA_W-1:0] right_d;
      if (g == 0) begin : g_first
         assign left_d = req_value;
      end else begin : g_mid_l
         assign left_d = cell_data[g-1];
      end
      if (g == CAP - 1) begin : g_last
         assign right_d = cell_data[g];
      end else begin : g_mid_r
         assign right_d = cell_data[g+1];
      end
      bale_cell u_cell (
         .clock      (clock),
         .op         (cell_op[g]),
         .left_data  (left_d),
         .right_data (right_d),
         .key        (req_value),
         .data       (cell_data[g]),
         .flags      (cell_flags[g])
      );
   end

   // first matching entry
   always_comb begin
      found_e   = '0;
      any_match = |match_v;
      for (int i = CAP - 1; i >= 0; i--) begin
         if (match_v[i]) begin
            found_e = CMP_W'(i);
         end
      end
   end

   // count update
   always_comb begin
      count_in = count_ff;
      if (accept) begin
         if (ins_ok || srt_ok) begin
            count_in = bale_pkg::CNT_W'(count_ff + bale_pkg::CNT_W'(1));
         end else if (del_ok) begin
            count_in = bale_pkg::CNT_W'(count_ff - bale_pkg::CNT_W'(1));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // result fields
   always_comb begin
      read_c = '0;
      case (req_kind)
         bale_pkg::KIND_INSERT_AT: begin
            if (pos_e > cnt_e) begin
               status_c = bale_pkg::ST_BAD_POS;
            end else if (cnt_e >= cap_e) begin
               status_c = bale_pkg::ST_FULL;
            end else begin
               status_c = bale_pkg::ST_OK;
            end
         end
         bale_pkg::KIND_DELETE_AT: begin
            status_c = del_ok ? bale_pkg::ST_OK : bale_pkg::ST_BAD_POS;
         end
         bale_pkg::KIND_LOCATE: begin
            status_c = any_match ? bale_pkg::ST_OK : bale_pkg::ST_MISSING;
         end
         bale_pkg::KIND_INSERT_SORTED: begin
            status_c = srt_ok ? bale_pkg::ST_OK : bale_pkg::ST_FULL;
         end
         bale_pkg::KIND_READ_AT: begin
            status_c = rd_ok ? bale_pkg::ST_OK : bale_pkg::ST_BAD_POS;
            if (rd_ok) begin
               read_c = cell_data[pos_e[bale_pkg::IDX_W-1:0]];
            end
         end
         default: status_c = bale_pkg::ST_BAD_POS;
      endcase
   end

   assign count_e_out  = CMP_W'(count_in);
   assign rsp_valid_in = accept | (rsp_valid_ff & rsp_stall);

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_c;
         found_ff  <= ((req_kind == bale_pkg::KIND_LOCATE) && any_match) ?
                      found_e[bale_pkg::FOUND_W-1:0] : '0;
         read_ff   <= read_c;
         entry_ff  <= count_e_out[bale_pkg::COUNT_W-1:0];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_found_index = found_ff;
   assign rsp_read_value  = read_ff;
   assign rsp_entry_count = entry_ff;

endmodule
`default_nettype wire

/* tb/bounded_array_list_engine_tb.sv */
`timescale 1ns / 1ps

module bounded_array_list_engine_tb;

   localparam int CYCLE_LIMIT  = 100000;
   localparam int DRAIN_CYCLES = 5;
   localparam int PRINT_CAP    = 100;
   localparam int PHASE_ITEMS  = 150;

   typedef struct {
      logic [bale_pkg::KIND_W-1:0]         kind;
      logic signed [bale_pkg::DATA_W-1:0]  value;
      logic [bale_pkg::POS_W-1:0]          position;
   } list_request_type;

   typedef struct {
      bale_pkg::status_type                status;
      logic [bale_pkg::FOUND_W-1:0]        found_index;
      logic signed [bale_pkg::DATA_W-1:0]  read_value;
      logic [bale_pkg::COUNT_W-1:0]        entry_count;
   } list_result_type;

   // dut ports
   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_stall;
   logic [bale_pkg::KIND_W-1:0]         req_kind = '0;
   logic signed [bale_pkg::DATA_W-1:0]  req_value = '0;
   logic [bale_pkg::POS_W-1:0]          req_position = '0;
   logic                                rsp_valid;
   logic                                rsp_stall = 1'b0;
   logic [bale_pkg::STATUS_W-1:0]       rsp_status;
   logic [bale_pkg::FOUND_W-1:0]        rsp_found_index;
   logic signed [bale_pkg::DATA_W-1:0]  rsp_read_value;
   logic [bale_pkg::COUNT_W-1:0]        rsp_entry_count;

   // stimulus and expectation queues
   list_request_type  pending_requests [$];
   list_result_type   expected_results [$];
   logic signed [bale_pkg::DATA_W-1:0] recent_values [$];

   // predicted list contents
   logic signed [bale_pkg::DATA_W-1:0] list_entries [bale_pkg::CAPACITY];
   int list_fill = 0;

   // fill level as the generator plans it
   int  plan_count = 0;
   bit  filling = 1'b1;

   // idling knobs
   int sender_idle_pct = 0;
   int stall_pct = 0;
   int idle_table [4]  = '{0, 84, 0, 34};
   int stall_table [4] = '{0, 0, 84, 34};

   // bookkeeping
   int error_count = 0;
   int cycle_count = 0;
   int requests_taken = 0;
   int beats_checked = 0;
   int full_rejects = 0;
   int locate_hits = 0;
   int peak_fill = 0;

   list_request_type  taken_request;
   list_result_type   want;

   bounded_array_list_engine uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_value       (req_value),
      .req_position    (req_position),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_found_index (rsp_found_index),
      .rsp_read_value  (rsp_read_value),
      .rsp_entry_count (rsp_entry_count)
   );

   // clock
   initial begin
      forever #1 clock = ~clock;
   end

   // predict one result and update the predicted list
   function automatic list_result_type apply_request(input list_request_type rq);
      list_result_type res;
      int i;
      res.status = bale_pkg::ST_OK;
      res.found_index = '0;
      res.read_value = '0;
      case (rq.kind)
         bale_pkg::KIND_INSERT_AT: begin
            // position beyond the count wins over a full list
            if (rq.position > list_fill) begin
               res.status = bale_pkg::ST_BAD_POS;
            end else if (list_fill >= bale_pkg::CAPACITY) begin
               res.status = bale_pkg::ST_FULL;
            end else begin
               for (i = list_fill; i > rq.position; i--)
                  list_entries[i] = list_entries[i-1];
               list_entries[rq.position] = rq.value;
               list_fill++;
            end
         end
         bale_pkg::KIND_DELETE_AT: begin
            if (rq.position >= list_fill) begin
               res.status = bale_pkg::ST_BAD_POS;
            end else begin
               for (i = rq.position; i + 1 < list_fill; i++)
                  list_entries[i] = list_entries[i+1];
               list_fill--;
            end
         end
         bale_pkg::KIND_LOCATE: begin
            res.status = bale_pkg::ST_MISSING;
            for (i = 0; i < list_fill; i++) begin
               if (res.status == bale_pkg::ST_MISSING && list_entries[i] == rq.value) begin
                  res.status = bale_pkg::ST_OK;
                  res.found_index = i[bale_pkg::FOUND_W-1:0];
               end
            end
         end
         bale_pkg::KIND_INSERT_SORTED: begin
            // shift from the end while entries are greater, sorted or not
            if (list_fill >= bale_pkg::CAPACITY) begin
               res.status = bale_pkg::ST_FULL;
            end else begin
               i = list_fill;
               while (i > 0 && list_entries[i-1] > rq.value) begin
                  list_entries[i] = list_entries[i-1];
                  i--;
               end
               list_entries[i] = rq.value;
               list_fill++;
            end
         end
         bale_pkg::KIND_READ_AT: begin
            if (rq.position >= list_fill)
               res.status = bale_pkg::ST_BAD_POS;
            else
               res.read_value = list_entries[rq.position];
         end
         default: begin
            res.status = bale_pkg::ST_BAD_POS;
         end
      endcase
      res.entry_count = list_fill[bale_pkg::COUNT_W-1:0];
      return res;
   endfunction

   task automatic report_error(input string msg);
      error_count++;
      if (error_count <= PRINT_CAP)
         $display("mismatch at result %0d: %s", beats_checked, msg);
   endtask

   // append a request and track the planned fill level
   task automatic queue_request(input logic [bale_pkg::KIND_W-1:0] kind,
                                input logic signed [bale_pkg::DATA_W-1:0] value,
                                input logic [bale_pkg::POS_W-1:0] position);
      list_request_type rq;
      bit grows;
      rq.kind = kind;
      rq.value = value;
      rq.position = position;
      pending_requests.push_back(rq);
      grows = (kind == bale_pkg::KIND_INSERT_AT && position <= plan_count &&
               plan_count < bale_pkg::CAPACITY) ||
              (kind == bale_pkg::KIND_INSERT_SORTED && plan_count < bale_pkg::CAPACITY);
      if (grows) begin
         plan_count++;
         recent_values.push_back(value);
         if (recent_values.size() > bale_pkg::CAPACITY)
            void'(recent_values.pop_front());
      end else if (kind == bale_pkg::KIND_DELETE_AT && position < plan_count) begin
         plan_count--;
      end
   endtask

   // values that repeat often enough for locate hits and duplicates
   function automatic logic signed [bale_pkg::DATA_W-1:0] pick_value();
      int bucket;
      bucket = $urandom_range(0, 9);
      if (bucket < 3 && recent_values.size() > 0)
         return recent_values[$urandom_range(0, recent_values.size() - 1)];
      else if (bucket < 6)
         return int'($urandom_range(0, 16)) - 8;
      else if (bucket == 6)
         return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      else
         return $urandom();
   endfunction

   // mostly a legal position below span, sometimes anything
   function automatic logic [bale_pkg::POS_W-1:0] pick_position(input int span);
      if (span <= 0 || $urandom_range(0, 7) == 0)
         return bale_pkg::POS_W'($urandom_range(0, 31));
      else
         return bale_pkg::POS_W'($urandom_range(0, span - 1));
   endfunction

   // random requests that sweep the list between empty and full
   task automatic queue_random(input int n);
      int roll;
      int grow_pct;
      int shrink_pct;
      repeat (n) begin
         if (plan_count >= bale_pkg::CAPACITY)
            filling = 1'b0;
         else if (plan_count == 0)
            filling = 1'b1;
         else if ($urandom_range(0, 39) == 0)
            filling = !filling;
         grow_pct = filling ? 50 : 15;
         shrink_pct = filling ? 15 : 45;
         roll = $urandom_range(0, 99);
         if (roll < grow_pct) begin
            if ($urandom_range(0, 1))
               queue_request(bale_pkg::KIND_INSERT_AT, pick_value(),
                             pick_position(plan_count + 1));
            else
               queue_request(bale_pkg::KIND_INSERT_SORTED, pick_value(),
                             bale_pkg::POS_W'($urandom_range(0, 31)));
         end else if (roll < grow_pct + shrink_pct) begin
            queue_request(bale_pkg::KIND_DELETE_AT, pick_value(), pick_position(plan_count));
         end else if (roll < grow_pct + shrink_pct + 14) begin
            queue_request(bale_pkg::KIND_LOCATE, pick_value(),
                          bale_pkg::POS_W'($urandom_range(0, 31)));
         end else if (roll < grow_pct + shrink_pct + 26) begin
            queue_request(bale_pkg::KIND_READ_AT, pick_value(), pick_position(plan_count));
         end else if (roll < grow_pct + shrink_pct + 30) begin
            queue_request(bale_pkg::KIND_W'($urandom_range(5, 7)), $urandom(),
                          bale_pkg::POS_W'($urandom_range(0, 31)));
         end else begin
            queue_request(bale_pkg::KIND_W'($urandom_range(0, 4)), $urandom(),
                          bale_pkg::POS_W'($urandom_range(0, 31)));
         end
      end
   endtask

   task automatic wait_drained();
      while (pending_requests.size() != 0 || expected_results.size() != 0)
         @(negedge clock);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid)
            void'(pending_requests.pop_front());
         if (pending_requests.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
            req_valid <= 1'b1;
            req_kind <= pending_requests[0].kind;
            req_value <= pending_requests[0].value;
            req_position <= pending_requests[0].position;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result stall
   always @(posedge clock) begin
      if (reset)
         rsp_stall <= 1'b0;
      else
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   // check result beats, then predict the request taken at this edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            beats_checked++;
            if (expected_results.size() == 0) begin
               report_error("result beat with no request waiting");
            end else begin
               want = expected_results.pop_front();
               if (rsp_status !== want.status)
                  report_error($sformatf("status got %0d want %0d", rsp_status, want.status));
               if (rsp_found_index !== want.found_index)
                  report_error($sformatf("found_index got %0d want %0d",
                                         rsp_found_index, want.found_index));
               if (rsp_read_value !== want.read_value)
                  report_error($sformatf("read_value got %h want %h",
                                         rsp_read_value, want.read_value));
               if (rsp_entry_count !== want.entry_count)
                  report_error($sformatf("entry_count got %0d want %0d",
                                         rsp_entry_count, want.entry_count));
            end
         end
         if (req_valid && !req_stall) begin
            requests_taken++;
            taken_request.kind = req_kind;
            taken_request.value = req_value;
            taken_request.position = req_position;
            expected_results.push_back(apply_request(taken_request));
            if (expected_results[$].status == bale_pkg::ST_FULL)
               full_rejects++;
            if (req_kind == bale_pkg::KIND_LOCATE &&
                expected_results[$].status == bale_pkg::ST_OK)
               locate_hits++;
            if (list_fill > peak_fill)
               peak_fill = list_fill;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // stimulus sequence
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: empty list, extremes, unsorted insert, unknown kinds
      queue_request(bale_pkg::KIND_READ_AT, 0, 0);
      queue_request(bale_pkg::KIND_DELETE_AT, 0, 0);
      queue_request(bale_pkg::KIND_LOCATE, 0, 0);
      queue_request(bale_pkg::KIND_INSERT_AT, 1, 1);
      queue_request(bale_pkg::KIND_INSERT_AT, 32'sh7FFF_FFFF, 0);
      queue_request(bale_pkg::KIND_INSERT_AT, 32'sh8000_0000, 1);
      queue_request(bale_pkg::KIND_INSERT_AT, 5, 31);
      queue_request(bale_pkg::KIND_INSERT_SORTED, 0, 0);
      queue_request(bale_pkg::KIND_INSERT_SORTED, -1, 31);
      queue_request(bale_pkg::KIND_INSERT_AT, 0, 0);
      queue_request(bale_pkg::KIND_LOCATE, 0, 0);
      queue_request(bale_pkg::KIND_LOCATE, 32'sh8000_0000, 0);
      queue_request(bale_pkg::KIND_LOCATE, 12345, 0);
      queue_request(bale_pkg::KIND_READ_AT, 0, 4);
      queue_request(bale_pkg::KIND_READ_AT, 0, 5);
      queue_request(bale_pkg::KIND_READ_AT, 0, 31);
      queue_request(bale_pkg::KIND_DELETE_AT, 0, 1);
      queue_request(bale_pkg::KIND_DELETE_AT, 0, 3);
      queue_request(3'd5, 32'sh7FFF_FFFF, 31);
      queue_request(3'd6, 32'sh8000_0000, 0);
      queue_request(3'd7, -1, 17);
      queue_request(bale_pkg::KIND_INSERT_SORTED, 32'sh7FFF_FFFF, 0);
      queue_request(bale_pkg::KIND_DELETE_AT, 0, 0);
      queue_request(bale_pkg::KIND_LOCATE, -1, 0);
      queue_request(bale_pkg::KIND_READ_AT, 0, 0);
      wait_drained();

      // fill to capacity, then the full-list cases
      while (plan_count < bale_pkg::CAPACITY)
         queue_request(bale_pkg::KIND_INSERT_SORTED, pick_value(), 0);
      queue_request(bale_pkg::KIND_INSERT_AT, 9, bale_pkg::CAPACITY);
      queue_request(bale_pkg::KIND_INSERT_AT, 9, bale_pkg::CAPACITY + 1);
      queue_request(bale_pkg::KIND_INSERT_SORTED, 9, 0);
      queue_request(bale_pkg::KIND_READ_AT, 0, bale_pkg::CAPACITY - 1);
      queue_request(bale_pkg::KIND_DELETE_AT, 0, bale_pkg::CAPACITY - 1);
      wait_drained();

      // random phases, sender paused at each boundary until all results are in
      for (int phase = 0; phase < 4; phase++) begin
         sender_idle_pct = idle_table[phase];
         stall_pct = stall_table[phase];
         queue_random(PHASE_ITEMS);
         wait_drained();
      end
      sender_idle_pct = 0;
      stall_pct = 0;

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_results.size() != 0)
         report_error("results still outstanding at end of run");

      $display("summary: %0d requests over four idling phases, %0d result beats checked",
               requests_taken, beats_checked);
      $display("summary: peak fill %0d of %0d, %0d full rejects, %0d locate hits, %0d cycles",
               peak_fill, bale_pkg::CAPACITY, full_rejects, locate_hits, cycle_count);
      if (error_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
